FILE: hdl/spc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spc_pkg: shared types and constants of the sprite pixel compositor
// Holds the table defaults, the item modes and the controller interface types.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int NUM_SPRITES_DEF  = 8;
    localparam int NUM_MISSILES_DEF = 4;
    localparam int PIXEL_WORDS_DEF  = 4096;
    localparam int MAX_SIDE_DEF     = 64;

    localparam int ADDR_W  = 12;
    localparam int SIDE_W  = 7;
    localparam int ANCH_W  = 9;

    typedef enum logic [1:0] {
        MODE_WR_SPRITE  = 2'd0,
        MODE_WR_MISSILE = 2'd1,
        MODE_WR_PIXEL   = 2'd2,
        MODE_RENDER     = 2'd3
    } mode_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the accepted word
        logic clr_scan;   // restart the object scan
        logic step_mis;   // test the current missile
        logic step_spr_a; // compute the current sprite's geometry
        logic step_spr_b; // test hit, issue pixel fetch
        logic step_spr_c; // compare fetched pixel against key
        logic out_load;   // move result to the output register
    } spc_cmd_t;

    typedef struct packed {
        logic mis_last;
        logic spr_last;
    } spc_stat_t;

endpackage
`default_nettype wire

FILE: hdl/sprite_pixel_compositor_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_pixel_compositor_top: sprite and missile pixel compositor
// A render word tests each missile in turn, then takes each sprite through three
// steps (anchor multiply, hit test with pixel memory read, color key compare).
// Write words are taken in the idle state and give no result. The finished
// color sits in an output register.
// ----------------------------------------------------------------------------
module sprite_pixel_compositor_top #(
    parameter int NUM_SPRITES  = spc_pkg::NUM_SPRITES_DEF,
    parameter int NUM_MISSILES = spc_pkg::NUM_MISSILES_DEF,
    parameter int PIXEL_WORDS  = spc_pkg::PIXEL_WORDS_DEF,
    parameter int MAX_SIDE     = spc_pkg::MAX_SIDE_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_mode,
    input  wire logic [3:0]         s_slot,
    input  wire logic signed [15:0] s_pos_x,
    input  wire logic signed [15:0] s_pos_y,
    input  wire logic [6:0]         s_width,
    input  wire logic [6:0]         s_height,
    input  wire logic [1:0]         s_scale,
    input  wire logic [8:0]         s_anchor_x,
    input  wire logic [8:0]         s_anchor_y,
    input  wire logic               s_active,
    input  wire logic [15:0]        s_color,
    input  wire logic [11:0]        s_address,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [15:0]             m_pixel_color,
    output logic                    m_drawn,
    output logic                    m_from_sprite
);
    import spc_pkg::*;

    spc_cmd_t  cmd;
    spc_stat_t stat;

    spc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_mode(s_mode), .m_valid(m_valid), .m_ready(m_ready),
        .cmd(cmd), .stat(stat)
    );

    spc_datapath #(
        .NUM_SPRITES(NUM_SPRITES), .NUM_MISSILES(NUM_MISSILES),
        .PIXEL_WORDS(PIXEL_WORDS), .MAX_SIDE(MAX_SIDE)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .s_mode(s_mode), .s_slot(s_slot), .s_pos_x(s_pos_x), .s_pos_y(s_pos_y),
        .s_width(s_width), .s_height(s_height), .s_scale(s_scale),
        .s_anchor_x(s_anchor_x), .s_anchor_y(s_anchor_y), .s_active(s_active),
        .s_color(s_color), .s_address(s_address),
        .m_pixel_color(m_pixel_color), .m_drawn(m_drawn),
        .m_from_sprite(m_from_sprite)
    );

endmodule
`default_nettype wire

FILE: hdl/spc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spc_ctrl: compositor controller
// Sequences writes and the per-object scan of a render word.
// ----------------------------------------------------------------------------
module spc_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_mode,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output spc_pkg::spc_cmd_t      cmd,
    input  wire spc_pkg::spc_stat_t stat
);
    import spc_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MIS  = 6'b000010,
        ST_SPA  = 6'b000100,
        ST_SPB  = 6'b001000,
        ST_SPC  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = accept;
                if (accept && s_mode == MODE_RENDER) begin
                    cmd.clr_scan = 1'b1;
                    state_next   = ST_MIS;
                end
            end
            ST_MIS: begin
                cmd.step_mis = 1'b1;
                if (stat.mis_last) state_next = ST_SPA;
            end
            ST_SPA: begin
                cmd.step_spr_a = 1'b1;
                state_next     = ST_SPB;
            end
            ST_SPB: begin
                cmd.step_spr_b = 1'b1;
                state_next     = ST_SPC;
            end
            ST_SPC: begin
                cmd.step_spr_c = 1'b1;
                state_next     = stat.spr_last ? ST_OUT : ST_SPA;
            end
            ST_OUT: begin
                // Wait until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_out_only_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside output state");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_ready)
        else $error("ready while busy");
    a_load_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwritten");

endmodule
`default_nettype wire

FILE: hdl/spc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spc_datapath: compositor datapath
// Object tables, pixel memory, a missile test and one shared sprite hit/fetch unit.
// ----------------------------------------------------------------------------
module spc_datapath #(
    parameter int NUM_SPRITES  = spc_pkg::NUM_SPRITES_DEF,
    parameter int NUM_MISSILES = spc_pkg::NUM_MISSILES_DEF,
    parameter int PIXEL_WORDS  = spc_pkg::PIXEL_WORDS_DEF,
    parameter int MAX_SIDE     = spc_pkg::MAX_SIDE_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire spc_pkg::spc_cmd_t  cmd,
    output spc_pkg::spc_stat_t      stat,
    input  wire logic [1:0]         s_mode,
    input  wire logic [3:0]         s_slot,
    input  wire logic signed [15:0] s_pos_x,
    input  wire logic signed [15:0] s_pos_y,
    input  wire logic [6:0]         s_width,
    input  wire logic [6:0]         s_height,
    input  wire logic [1:0]         s_scale,
    input  wire logic [8:0]         s_anchor_x,
    input  wire logic [8:0]         s_anchor_y,
    input  wire logic               s_active,
    input  wire logic [15:0]        s_color,
    input  wire logic [11:0]        s_address,
    output logic [15:0]             m_pixel_color,
    output logic                    m_drawn,
    output logic                    m_from_sprite
);
    import spc_pkg::*;

    localparam int SI_W = (NUM_SPRITES > 1) ? $clog2(NUM_SPRITES) : 1;
    localparam int MI_W = (NUM_MISSILES > 1) ? $clog2(NUM_MISSILES) : 1;
    localparam int PA_W = $clog2(PIXEL_WORDS);
    localparam logic [SIDE_W-1:0] MAX_S = SIDE_W'(MAX_SIDE);

    // Object tables.
    logic signed [15:0] spr_x [NUM_SPRITES];
    logic signed [15:0] spr_y [NUM_SPRITES];
    logic [SIDE_W-1:0]  spr_w [NUM_SPRITES];
    logic [SIDE_W-1:0]  spr_h [NUM_SPRITES];
    logic [1:0]         spr_s [NUM_SPRITES];
    logic [ANCH_W-1:0]  spr_ax [NUM_SPRITES];
    logic [ANCH_W-1:0]  spr_ay [NUM_SPRITES];
    logic [15:0]        spr_k [NUM_SPRITES];
    logic [ADDR_W-1:0]  spr_b [NUM_SPRITES];
    logic               spr_act [NUM_SPRITES];
    logic signed [15:0] mis_x [NUM_MISSILES];
    logic signed [15:0] mis_y [NUM_MISSILES];
    logic [SIDE_W-1:0]  mis_w [NUM_MISSILES];
    logic [SIDE_W-1:0]  mis_h [NUM_MISSILES];
    logic [1:0]         mis_s [NUM_MISSILES];
    logic [15:0]        mis_c [NUM_MISSILES];
    logic               mis_act [NUM_MISSILES];

    logic [15:0] pix_mem [PIXEL_WORDS];
    logic [15:0] pix_rd_reg;

    logic [SIDE_W-1:0] w_cl, h_cl;
    logic [SI_W-1:0]   sslot;
    logic [MI_W-1:0]   mslot;

    // A limit above the largest field value never clamps.
    assign w_cl  = (32'(s_width) > MAX_SIDE) ? MAX_S : s_width;
    assign h_cl  = (32'(s_height) > MAX_SIDE) ? MAX_S : s_height;
    assign sslot = (32'(s_slot) >= NUM_SPRITES) ? SI_W'(NUM_SPRITES - 1) : SI_W'(s_slot);
    assign mslot = (32'(s_slot) >= NUM_MISSILES) ? MI_W'(NUM_MISSILES - 1) : MI_W'(s_slot);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SPRITES; i++) begin
                spr_x[i] <= '0; spr_y[i] <= '0; spr_w[i] <= '0; spr_h[i] <= '0;
                spr_s[i] <= '0; spr_ax[i] <= '0; spr_ay[i] <= '0; spr_k[i] <= '0;
                spr_b[i] <= '0; spr_act[i] <= 1'b0;
            end
            for (int i = 0; i < NUM_MISSILES; i++) begin
                mis_x[i] <= '0; mis_y[i] <= '0; mis_w[i] <= '0; mis_h[i] <= '0;
                mis_s[i] <= '0; mis_c[i] <= '0; mis_act[i] <= 1'b0;
            end
        end else if (cmd.load && s_mode == MODE_WR_SPRITE) begin
            spr_x[sslot] <= s_pos_x;  spr_y[sslot] <= s_pos_y;
            spr_w[sslot] <= w_cl;     spr_h[sslot] <= h_cl;
            spr_s[sslot] <= s_scale;
            spr_ax[sslot] <= s_anchor_x; spr_ay[sslot] <= s_anchor_y;
            spr_k[sslot] <= s_color;  spr_b[sslot] <= s_address;
            spr_act[sslot] <= s_active;
        end else if (cmd.load && s_mode == MODE_WR_MISSILE) begin
            mis_x[mslot] <= s_pos_x;  mis_y[mslot] <= s_pos_y;
            mis_w[mslot] <= w_cl;     mis_h[mslot] <= h_cl;
            mis_s[mslot] <= s_scale;  mis_c[mslot] <= s_color;
            mis_act[mslot] <= s_active;
        end
    end

    // Render word registers.
    logic signed [15:0] px_reg, py_reg;
    logic [15:0]        res_reg;
    logic               drawn_reg, fspr_reg;
    logic [MI_W-1:0]    mi_reg;
    logic [SI_W-1:0]    si_reg;

    // Missile test.
    logic signed [17:0] mx0, my0, mx1, my1;
    logic [7:0]         mw2, mh2;
    logic               mhit;
    assign mw2  = mis_s[mi_reg][0] ? {mis_w[mi_reg], 1'b0} : {1'b0, mis_w[mi_reg]};
    assign mh2  = mis_s[mi_reg][1] ? {mis_h[mi_reg], 1'b0} : {1'b0, mis_h[mi_reg]};
    assign mx0  = 18'(mis_x[mi_reg]);
    assign my0  = 18'(mis_y[mi_reg]);
    assign mx1  = mx0 + 18'(mw2);
    assign my1  = my0 + 18'(mh2);
    assign mhit = mis_act[mi_reg] && (mis_w[mi_reg] != '0) && (mis_h[mi_reg] != '0)
               && (18'(px_reg) >= mx0) && (18'(px_reg) < mx1)
               && (18'(py_reg) >= my0) && (18'(py_reg) < my1);

    // Sprite stage A: anchor offsets (one 9x8 multiply per axis).
    logic [7:0]  sw2, sh2;
    logic [16:0] offx_prod, offy_prod;
    logic [8:0]  offx_reg, offy_reg;
    logic [7:0]  sw_reg, sh_reg;
    assign sw2 = spr_s[si_reg][0] ? {spr_w[si_reg], 1'b0} : {1'b0, spr_w[si_reg]};
    assign sh2 = spr_s[si_reg][1] ? {spr_h[si_reg], 1'b0} : {1'b0, spr_h[si_reg]};
    assign offx_prod = 17'(spr_ax[si_reg] * (sw2 - 8'd1)) + 17'd128;
    assign offy_prod = 17'(spr_ay[si_reg] * (sh2 - 8'd1)) + 17'd128;

    // Sprite stage B: hit test and source address.
    logic signed [18:0] left, top, dxs, dys;
    logic               shit;
    logic [7:0]         dxu, dyu;
    logic [6:0]         col, row;
    logic [ADDR_W+6:0]  src_addr;
    logic               hit_reg;
    assign left = 19'(spr_x[si_reg]) - 19'(offx_reg);
    assign top  = 19'(spr_y[si_reg]) - 19'(offy_reg);
    assign dxs  = 19'(px_reg) - left;
    assign dys  = 19'(py_reg) - top;
    assign shit = spr_act[si_reg] && (spr_w[si_reg] != '0) && (spr_h[si_reg] != '0)
               && !dxs[18] && !dys[18] && (dxs < 19'(sw_reg)) && (dys < 19'(sh_reg));
    assign dxu  = dxs[7:0];
    assign dyu  = dys[7:0];
    assign col  = spr_s[si_reg][0] ? dxu[7:1] : dxu[6:0];
    assign row  = spr_s[si_reg][1] ? dyu[7:1] : dyu[6:0];
    assign src_addr = (ADDR_W+7)'(spr_b[si_reg]) + (ADDR_W+7)'(row * spr_w[si_reg])
                    + (ADDR_W+7)'(col);

    assign stat.mis_last = (32'(mi_reg) == NUM_MISSILES - 1);
    assign stat.spr_last = (32'(si_reg) == NUM_SPRITES - 1);

    always_ff @(posedge aclk) begin
        if (cmd.load && s_mode == MODE_WR_PIXEL)
            pix_mem[PA_W'(s_address)] <= s_color;
        pix_rd_reg <= pix_mem[PA_W'(src_addr)];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            px_reg    <= s_pos_x;
            py_reg    <= s_pos_y;
            res_reg   <= s_color;
            drawn_reg <= 1'b0;
            fspr_reg  <= 1'b0;
        end
        if (cmd.clr_scan) begin
            mi_reg <= '0;
            si_reg <= '0;
        end
        if (cmd.step_mis) begin
            if (mhit) begin
                res_reg   <= mis_c[mi_reg];
                drawn_reg <= 1'b1;
                fspr_reg  <= 1'b0;
            end
            if (!stat.mis_last) mi_reg <= mi_reg + MI_W'(1);
        end
        if (cmd.step_spr_a) begin
            offx_reg <= offx_prod[16:8];
            offy_reg <= offy_prod[16:8];
            sw_reg   <= sw2;
            sh_reg   <= sh2;
        end
        if (cmd.step_spr_b) hit_reg <= shit;
        if (cmd.step_spr_c) begin
            if (hit_reg && pix_rd_reg != spr_k[si_reg]) begin
                res_reg   <= pix_rd_reg;
                drawn_reg <= 1'b1;
                fspr_reg  <= 1'b1;
            end
            if (!stat.spr_last) si_reg <= si_reg + SI_W'(1);
        end
        if (cmd.out_load) begin
            m_pixel_color <= res_reg;
            m_drawn       <= drawn_reg;
            m_from_sprite <= fspr_reg;
        end
    end

    a_fspr_implies_drawn: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step_spr_b |=> !fspr_reg || drawn_reg)
        else $error("sprite win without drawn");
    a_one_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.step_mis, cmd.step_spr_a, cmd.step_spr_b, cmd.step_spr_c,
                  cmd.out_load}))
        else $error("overlapping datapath commands");
    a_spr_order: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step_spr_c |-> $past(cmd.step_spr_b))
        else $error("key compare without fetch");

endmodule
`default_nettype wire
